@@ hdl/bvma_pkg.sv @@
`timescale 1ns / 1ps

package bvma_pkg;

  // Window and converter geometry
  localparam int WINDOW_DEPTH = 8;
  localparam int SAMPLE_BITS  = 12;

  // Field widths
  localparam int VALUE_W   = 16;
  localparam int CFG_IDX_W = 4;

  // Derived widths
  localparam int POS_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = VALUE_W + $clog2(WINDOW_DEPTH);
  localparam int PROD_W  = SAMPLE_BITS + VALUE_W;
  localparam int DIV_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int STEP_W  = $clog2(DIV_W + 1);

  // Register reset values
  localparam logic [VALUE_W-1:0] FULL_SCALE_RESET = VALUE_W'(4200);
  localparam logic [VALUE_W-1:0] TOP_CODE_RESET   = VALUE_W'(4095);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_CODE   = CFG_IDX_W'(1);

  // Controller to datapath commands
  typedef struct packed {
    logic load_sample;
    logic load_product;
    logic start_scale;
    logic start_mean;
    logic update;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/bvma_divider.sv @@
`timescale 1ns / 1ps

module bvma_divider
  import bvma_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [STEP_W-1:0]  steps_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [VALUE_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quotient_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  count_q, count_d;
  logic [DIV_W-1:0]   dvd_q, dvd_d;
  logic [VALUE_W-1:0] dvs_q, dvs_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VALUE_W:0]   rem_shift;
  logic [VALUE_W:0]   rem_diff;
  logic               fits;

  // One restoring step: bring down the next dividend bit and try the subtract
  assign rem_shift = {rem_q, dvd_q[DIV_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs_q};
  assign fits      = (rem_shift >= {1'b0, dvs_q});

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    count_d = count_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      count_d = steps_i;
      dvd_d   = dividend_i;
      dvs_d   = divisor_i;
      rem_d   = '0;
    end else if (busy_q) begin
      // Quotient bits shift in behind the consumed dividend bits
      dvd_d   = {dvd_q[DIV_W-2:0], fits};
      rem_d   = fits ? rem_diff[VALUE_W-1:0] : rem_shift[VALUE_W-1:0];
      count_d = count_q - STEP_W'(1);
      if (count_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ hdl/bvma_datapath.sv @@
`timescale 1ns / 1ps

module bvma_datapath
  import bvma_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [SAMPLE_BITS-1:0] raw_sample_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [VALUE_W-1:0]     cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_W-1:0]     average_voltage_o
);

  logic [VALUE_W-1:0]     full_scale_q;
  logic [VALUE_W-1:0]     top_code_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [PROD_W-1:0]      prod_q;
  logic [VALUE_W-1:0]     ring_q [WINDOW_DEPTH];
  logic [POS_W-1:0]       pos_q;
  logic [COUNT_W-1:0]     count_q;
  logic [SUM_W-1:0]       sum_q;
  logic                   out_valid_q;
  logic [VALUE_W-1:0]     out_q;

  logic               div_start;
  logic [STEP_W-1:0]  div_steps;
  logic [DIV_W-1:0]   div_dividend;
  logic [VALUE_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quotient;
  logic [VALUE_W-1:0] scaled;
  logic [SUM_W-1:0]   sum_next;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RESET;
      top_code_q   <= TOP_CODE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FULL_SCALE: full_scale_q <= cfg_data_i;
        REG_TOP_CODE:   top_code_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the sample, then form the scaling product
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= raw_sample_i;
    end
    if (cmd_i.load_product) begin
      prod_q <= PROD_W'(sample_q) * PROD_W'(full_scale_q);
    end
  end

  // Shared serial divider: scaling first, then the mean
  assign div_start = cmd_i.start_scale | cmd_i.start_mean;

  always_comb begin
    if (cmd_i.start_mean) begin
      div_steps    = STEP_W'(SUM_W);
      div_dividend = DIV_W'(sum_q) << (DIV_W - SUM_W);
      div_divisor  = VALUE_W'(count_q);
    end else begin
      div_steps    = STEP_W'(PROD_W);
      div_dividend = DIV_W'(prod_q) << (DIV_W - PROD_W);
      div_divisor  = top_code_q;
    end
  end

  bvma_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // A zero top code saturates the scaled value
  assign scaled   = (top_code_q == '0) ? '1 : div_quotient[VALUE_W-1:0];
  assign sum_next = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(scaled);

  // Window state: replace the oldest entry and keep the running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      pos_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (cmd_i.update) begin
      ring_q[pos_q] <= scaled;
      sum_q         <= sum_next;
      if (pos_q == POS_W'(WINDOW_DEPTH - 1)) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (count_q != COUNT_W'(WINDOW_DEPTH)) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= div_quotient[VALUE_W-1:0];
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign average_voltage_o = out_q;

endmodule

@@ hdl/bvma_ctrl.sv @@
`timescale 1ns / 1ps

module bvma_ctrl
  import bvma_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SCALE_GO,
    S_SCALE_WAIT,
    S_UPDATE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_OUT
  } state_e;

  state_e state_q;
  logic   in_take;

  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // Sequence one item through scaling, window update and mean
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_o   <= '0;
    end else begin
      cmd_o <= '0;
      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            state_q           <= S_MUL;
            cmd_o.load_product <= 1'b1;
          end
        end
        S_MUL: begin
          state_q           <= S_SCALE_GO;
          cmd_o.start_scale <= 1'b1;
        end
        S_SCALE_GO: begin
          state_q <= S_SCALE_WAIT;
        end
        S_SCALE_WAIT: begin
          if (sts_i.div_done) begin
            state_q      <= S_UPDATE;
            cmd_o.update <= 1'b1;
          end
        end
        S_UPDATE: begin
          state_q          <= S_MEAN_GO;
          cmd_o.start_mean <= 1'b1;
        end
        S_MEAN_GO: begin
          state_q <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (sts_i.out_free) begin
            state_q        <= S_IDLE;
            cmd_o.load_out <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // The sample is captured in the cycle of the transaction itself
    end
  end

endmodule

@@ hdl/battery_voltage_moving_average.sv @@
`timescale 1ns / 1ps
// An input transaction is worked through by the shared bit-serial divider, which runs
// PROD_W steps for scaling and SUM_W steps for the mean; the block takes no new item
// until the result of the last one has been loaded into the output register.
// A new item is taken while the previous result still waits in the output register.
// Reset (asynchronous, active low) clears the window, running sum, fill count and
// returns the configuration registers to their reset values.

module battery_voltage_moving_average
  import bvma_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] raw_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_W-1:0]     average_voltage_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [VALUE_W-1:0]     cfg_data_i
);

  cmd_t ctrl_cmd;
  cmd_t dp_cmd;
  sts_t dp_sts;

  bvma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  // Capture the sample on the input transaction; the rest comes registered
  always_comb begin
    dp_cmd             = ctrl_cmd;
    dp_cmd.load_sample = in_valid_i && !in_stall_o;
  end

  bvma_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .sts_o             (dp_sts),
    .raw_sample_i      (raw_sample_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .average_voltage_o (average_voltage_o)
  );

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

endmodule

@@ hdl/bvma_checker.sv @@
`timescale 1ns / 1ps

module bvma_checker
  import bvma_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [VALUE_W-1:0] average_voltage_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_voltage_o))
    else $error("stalled result changed");

  // An accepted item keeps the input stalled while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too early");

  // A new result only appears at the end of an item's work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o, 2))
    else $error("result without an item in work");

  // Registers are always writable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind battery_voltage_moving_average bvma_checker u_bvma_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .average_voltage_o (average_voltage_o),
  .cfg_valid_i       (cfg_valid_i),
  .cfg_ready_o       (cfg_ready_o)
);

@@ verif/battery_voltage_moving_average_tb.sv @@
`timescale 1ns / 1ps

module battery_voltage_moving_average_tb;
  import bvma_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned MAX_WAIT     = 18;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 72;
  localparam int unsigned BURST_ITEMS  = 8;

  // Indexes beyond the register file, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_TOP_CODE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  // Scaling, window and running mean kept alongside the block
  class voltage_window_model;
    logic [VALUE_W-1:0] full_scale;
    logic [VALUE_W-1:0] top_code;
    logic [VALUE_W-1:0] window [WINDOW_DEPTH];
    int unsigned        slot;
    int unsigned        fill;
    logic [SUM_W-1:0]   window_sum;
    logic [VALUE_W-1:0] expected_means [$];
    int unsigned        mismatches;

    function new();
      full_scale = FULL_SCALE_RESET;
      top_code   = TOP_CODE_RESET;
      foreach (window[i]) window[i] = '0;
      slot       = 0;
      fill       = 0;
      window_sum = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
      case (idx)
        REG_FULL_SCALE: full_scale = data;
        REG_TOP_CODE:   top_code = data;
        default: ;
      endcase
    endfunction

    // Zero top code saturates; otherwise keep the low VALUE_W bits of the quotient
    function logic [VALUE_W-1:0] scaled_voltage(logic [SAMPLE_BITS-1:0] raw);
      logic [SAMPLE_BITS+VALUE_W-1:0] product;
      if (top_code == '0) return '1;
      product = raw * full_scale;
      return VALUE_W'(product / top_code);
    endfunction

    // Replace the oldest entry and queue the mean over the filled entries
    function void note_sample(logic [SAMPLE_BITS-1:0] raw);
      logic [VALUE_W-1:0] scaled;
      logic [SUM_W-1:0]   mean;
      scaled       = scaled_voltage(raw);
      window_sum   = window_sum - window[slot] + scaled;
      window[slot] = scaled;
      slot         = (slot == WINDOW_DEPTH - 1) ? 0 : slot + 1;
      if (fill < WINDOW_DEPTH) fill++;
      mean = SUM_W'(window_sum / fill);
      expected_means.push_back(VALUE_W'(mean));
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_average(input logic [VALUE_W-1:0] got);
      logic [VALUE_W-1:0] want;
      if (expected_means.size() == 0) begin
        report_mismatch($sformatf("average_voltage %0d with no sample outstanding", got));
      end else begin
        want = expected_means.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("average_voltage %0d, expected %0d", got, want));
        end
      end
    endtask
  endclass

  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   in_valid_i        = 1'b0;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] raw_sample_i      = '0;
  logic                   out_valid_o;
  logic                   out_stall_i       = 1'b0;
  logic [VALUE_W-1:0]     average_voltage_o;
  logic                   cfg_valid_i       = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i       = '0;
  logic [VALUE_W-1:0]     cfg_data_i        = '0;

  voltage_window_model window_model = new();
  bit no_idle     = 1'b0;
  bit hold_output = 1'b0;

  battery_voltage_moving_average i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_sample_i      (raw_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .average_voltage_o (average_voltage_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Offer one sample after a random gap and hold it until taken
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write
  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VALUE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [VALUE_W-1:0] full_scale,
                           input logic [VALUE_W-1:0] top_code, input bit stray);
    program_register(REG_FULL_SCALE, full_scale);
    program_register(REG_TOP_CODE, top_code);
    if (stray) begin
      program_register(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                       VALUE_W'($urandom_range(0, 16'hFFFF)));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Drop the input and wait for every outstanding average to come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (window_model.expected_means.size() != 0);
    @(posedge clk_i);
  endtask

  // Record transactions on every channel; results first, as they are older
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) window_model.check_average(average_voltage_o);
      if (cfg_valid_i && cfg_ready_o) window_model.write_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) window_model.note_sample(raw_sample_i);
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned pause;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        pause       = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        pause = draw_wait();
      end
      if (pause != 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0]     full_scale;
    logic [VALUE_W-1:0]     top_code;
    logic [SAMPLE_BITS-1:0] raw;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: partial window, extremes, alternating bits, then wrap
    send_sample('0);
    send_sample('1);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h001);
    send_sample(12'h800);
    send_sample('1);
    send_sample('1);
    send_sample('1);

    // Oversized quotient: only the low VALUE_W bits survive
    wait_idle();
    configure('1, 16'd1, 1'b0);
    send_sample('1);
    send_sample(12'h001);
    send_sample(12'h7FF);

    // Zero top code saturates the scaled value
    wait_idle();
    configure(16'd4200, '0, 1'b0);
    send_sample('0);
    send_sample('1);

    // Zero full scale, largest top code, and a write to an unused index
    wait_idle();
    configure('0, '1, 1'b1);
    send_sample('1);
    send_sample('0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: full_scale = '1;
        1: full_scale = VALUE_W'($urandom_range(0, 255));
        default: full_scale = VALUE_W'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 7))
        0: top_code = '0;
        1: top_code = '1;
        2: top_code = VALUE_W'($urandom_range(1, 15));
        default: top_code = VALUE_W'($urandom_range(1, 16'hFFFF));
      endcase
      configure(full_scale, top_code, $urandom_range(0, 2) == 0);
      no_idle = (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the result side while samples keep coming back to back
        if (phase == 3 && n == 20) begin
          hold_output = 1'b1;
          no_idle     = 1'b1;
        end
        if (phase == 3 && n == 20 + BURST_ITEMS) no_idle = 1'b0;
        case ($urandom_range(0, 7))
          0: raw = '0;
          1: raw = '1;
          2: raw = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
          default: raw = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
        endcase
        send_sample(raw);
      end
    end
    no_idle = 1'b0;

    // Drain, then watch for stray results
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (window_model.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
